// File: rtl/vfr_pkg.sv
package vfr_pkg;

   // field and state widths
   localparam int VOL_W    = 23;
   localparam int FRAC_W   = 16;
   localparam int TGT_W    = 7;
   localparam int TIME_W   = 16;
   localparam int PERIOD_W = 16;
   localparam int STEP_W   = 25;
   localparam int MASK_W   = 6;
   localparam int OUT_CH   = 6;
   localparam int PROD_W   = VOL_W + PERIOD_W;
   localparam int QUO_W    = STEP_W - 1;
   localparam int CNT_W    = 5;

   localparam logic [VOL_W-1:0]        FULL_SCALE   = 23'd8323072;
   localparam logic [PERIOD_W-1:0]     PERIOD_RESET = 16'd16;
   localparam logic signed [STEP_W-1:0] STEP_MAX    = 25'sh0FFFFFF;
   localparam logic signed [STEP_W-1:0] STEP_MIN    = 25'sh1000000;

   // command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_TICK,
      ST_OUT
   } fade_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_CHK,
      MD_DIV
   } md_state_type;

   typedef struct packed {
      logic                start;
      logic [VOL_W-1:0]    mag;
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   duration;
   } md_req_type;

   typedef struct packed {
      logic             done;
      logic             sat;
      logic [QUO_W-1:0] quo;
   } md_rsp_type;

endpackage

// File: rtl/vfr_muldiv.sv
// bit-serial |diff| * period / duration: shift-add multiply, then restoring divide
module vfr_muldiv (
   input  logic               clock,
   input  logic               reset,
   input  vfr_pkg::md_req_type md_req,
   output vfr_pkg::md_rsp_type md_rsp
);
   import vfr_pkg::*;

   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(PERIOD_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);

   md_state_type        state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [VOL_W-1:0]    mag_ff, mag_in;
   logic [TIME_W-1:0]   dur_ff, dur_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic                sat_ff, sat_in;
   logic                done_ff, done_in;

   logic [VOL_W:0]      mul_sum;
   logic [TIME_W:0]     trial;
   logic [TIME_W:0]     trial_diff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      mag_ff  <= mag_in;
      dur_ff  <= dur_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      sat_ff  <= sat_in;
   end

   // one multiplier bit or one quotient bit per cycle
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      mag_in     = mag_ff;
      dur_in     = dur_ff;
      prod_in    = prod_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      sat_in     = sat_ff;
      done_in    = 1'b0;
      mul_sum    = {1'b0, prod_ff[PROD_W-1:PERIOD_W]}
                 + (prod_ff[0] ? {1'b0, mag_ff} : '0);
      trial      = {rem_ff, quo_ff[QUO_W-1]};
      trial_diff = trial - {1'b0, dur_ff};
      unique case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               mag_in   = md_req.mag;
               dur_in   = md_req.duration;
               prod_in  = {{VOL_W{1'b0}}, md_req.period};
               cnt_in   = '0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            prod_in = {mul_sum, prod_ff[PERIOD_W-1:1]};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = MD_CHK;
            end
         end
         MD_CHK: begin
            // quotient of 2^24 or more saturates, so the divide needs 24 bits only
            sat_in = {1'b0, prod_ff} >= {dur_ff, {QUO_W{1'b0}}};
            rem_in = {1'b0, prod_ff[PROD_W-1:QUO_W]};
            quo_in = prod_ff[QUO_W-1:0];
            cnt_in = '0;
            if ({1'b0, prod_ff} >= {dur_ff, {QUO_W{1'b0}}}) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end else begin
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            if (trial >= {1'b0, dur_ff}) begin
               rem_in = trial_diff[TIME_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = trial[TIME_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.sat  = sat_ff;
   assign md_rsp.quo  = quo_ff;

endmodule

// File: rtl/volume_fade_ramp.sv
// channel   direction  ports                                          handshake
// req       in         req_command, req_target_volume, req_fade_time  req_valid / req_stall
// rsp       out        rsp_volume_ch0..5, rsp_fading_mask             rsp_valid / rsp_stall
// csr       in         csr_wr_data (timer_period)                     csr_wr_en, no wait
//
// one word at a time; req_stall is high from accept until the result is loaded
// start with nonzero fade time: each channel in turn through one shared serial unit (launch,
// 16 multiply bits, range check, 24 quotient bits, write back); a saturating channel skips
// the quotient bits
// start with zero fade time: all channels set at once; tick: one channel a cycle
// the result register frees the core: a new word is taken while rsp_stall holds one
// synchronous reset; no clearing pass is needed
module volume_fade_ramp #(
   parameter int CHANNELS = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic [vfr_pkg::TGT_W-1:0]        req_target_volume,
   input  logic [vfr_pkg::TIME_W-1:0]       req_fade_time,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [vfr_pkg::VOL_W-1:0]        rsp_volume_ch0,
   output logic [vfr_pkg::VOL_W-1:0]        rsp_volume_ch1,
   output logic [vfr_pkg::VOL_W-1:0]        rsp_volume_ch2,
   output logic [vfr_pkg::VOL_W-1:0]        rsp_volume_ch3,
   output logic [vfr_pkg::VOL_W-1:0]        rsp_volume_ch4,
   output logic [vfr_pkg::VOL_W-1:0]        rsp_volume_ch5,
   output logic [vfr_pkg::MASK_W-1:0]       rsp_fading_mask,
   input  logic                             csr_wr_en,
   input  logic [vfr_pkg::PERIOD_W-1:0]     csr_wr_data
);
   import vfr_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

   fade_state_type             state_ff, state_in;
   logic [CH_W-1:0]            idx_ff, idx_in;
   logic [PERIOD_W-1:0]        period_ff, period_in;
   logic [VOL_W-1:0]           target_ff, target_in;
   logic [TIME_W-1:0]          dur_ff, dur_in;
   logic                       neg_ff, neg_in;
   logic                       nz_ff, nz_in;
   logic [VOL_W-1:0]           vol_ff [CHANNELS];
   logic [VOL_W-1:0]           vol_in [CHANNELS];
   logic signed [STEP_W-1:0]   step_ff [CHANNELS];
   logic signed [STEP_W-1:0]   step_in [CHANNELS];

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [VOL_W-1:0]           rsp_vol_ff [OUT_CH];
   logic [VOL_W-1:0]           rsp_vol_in [OUT_CH];
   logic [MASK_W-1:0]          rsp_mask_ff, rsp_mask_in;

   logic [VOL_W-1:0]           vol_view [OUT_CH];
   logic [MASK_W-1:0]          mask_view;

   md_req_type                 md_req;
   md_rsp_type                 md_rsp;

   logic signed [VOL_W:0]      diff;
   logic [VOL_W:0]             diff_abs;
   logic [QUO_W-1:0]           quo_fix;
   logic signed [STEP_W-1:0]   quo_step;
   logic signed [STEP_W-1:0]   cur_step;
   logic signed [STEP_W:0]     tick_sum;
   logic signed [STEP_W:0]     tgt_wide;
   logic                       tick_done;
   logic                       out_free;

   // shared serial multiply / divide
   vfr_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_RESET;
         target_ff    <= FULL_SCALE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            vol_ff[c]  <= FULL_SCALE;
            step_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < CHANNELS; c++) begin
            vol_ff[c]  <= vol_in[c];
            step_ff[c] <= step_in[c];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      dur_ff      <= dur_in;
      neg_ff      <= neg_in;
      nz_ff       <= nz_in;
      rsp_mask_ff <= rsp_mask_in;
      for (int c = 0; c < OUT_CH; c++) begin
         rsp_vol_ff[c] <= rsp_vol_in[c];
      end
   end

   // reported view: absent channels read zero
   always_comb begin
      mask_view = '0;
      for (int c = 0; c < OUT_CH; c++) begin
         if (c < CHANNELS) begin
            vol_view[c]  = vol_ff[c];
            mask_view[c] = (step_ff[c] != '0);
         end else begin
            vol_view[c] = '0;
         end
      end
   end

   // difference of the selected channel to the target, as sign and magnitude
   always_comb begin
      diff     = $signed({1'b0, target_ff}) - $signed({1'b0, vol_ff[idx_ff]});
      diff_abs = diff[VOL_W] ? -diff : diff;
   end

   // quotient to signed step: one-lsb floor for tiny steps, saturation
   always_comb begin
      quo_fix = (md_rsp.quo == '0 && nz_ff) ? QUO_W'(1) : md_rsp.quo;
      if (md_rsp.sat) begin
         quo_step = neg_ff ? STEP_MIN : STEP_MAX;
      end else if (neg_ff) begin
         quo_step = -$signed({1'b0, quo_fix});
      end else begin
         quo_step = $signed({1'b0, quo_fix});
      end
   end

   // tick on the selected channel
   always_comb begin
      cur_step  = step_ff[idx_ff];
      tick_sum  = $signed({3'b000, vol_ff[idx_ff]}) + $signed({cur_step[STEP_W-1], cur_step});
      tgt_wide  = $signed({3'b000, target_ff});
      tick_done = cur_step[STEP_W-1] ? (tick_sum <= tgt_wide) : (tick_sum >= tgt_wide);
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      period_in    = csr_wr_en ? csr_wr_data : period_ff;
      target_in    = target_ff;
      dur_in       = dur_ff;
      neg_in       = neg_ff;
      nz_in        = nz_ff;
      vol_in       = vol_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_vol_in   = rsp_vol_ff;
      rsp_mask_in  = rsp_mask_ff;
      req_stall    = 1'b1;

      md_req.start    = 1'b0;
      md_req.mag      = diff_abs[VOL_W-1:0];
      md_req.period   = period_ff;
      md_req.duration = dur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               idx_in = '0;
               dur_in = req_fade_time;
               if (req_command == CMD_TICK) begin
                  state_in = ST_TICK;
               end else begin
                  target_in = {req_target_volume, {FRAC_W{1'b0}}};
                  if (req_fade_time == '0) begin
                     // immediate set of every channel
                     for (int c = 0; c < CHANNELS; c++) begin
                        vol_in[c]  = {req_target_volume, {FRAC_W{1'b0}}};
                        step_in[c] = '0;
                     end
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_START;
                  end
               end
            end
         end
         ST_START: begin
            md_req.start = 1'b1;
            neg_in       = diff[VOL_W];
            nz_in        = (diff != '0);
            state_in     = ST_WAIT;
         end
         ST_WAIT: begin
            if (md_rsp.done) begin
               step_in[idx_ff] = quo_step;
               if (idx_ff == CH_LAST) begin
                  state_in = ST_OUT;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_START;
               end
            end
         end
         ST_TICK: begin
            if (cur_step != '0) begin
               if (tick_done) begin
                  vol_in[idx_ff]  = target_ff;
                  step_in[idx_ff] = '0;
               end else begin
                  vol_in[idx_ff] = tick_sum[VOL_W-1:0];
               end
            end
            if (idx_ff == CH_LAST) begin
               state_in = ST_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_vol_in   = vol_view;
               rsp_mask_in  = mask_view;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_volume_ch0  = rsp_vol_ff[0];
   assign rsp_volume_ch1  = rsp_vol_ff[1];
   assign rsp_volume_ch2  = rsp_vol_ff[2];
   assign rsp_volume_ch3  = rsp_vol_ff[3];
   assign rsp_volume_ch4  = rsp_vol_ff[4];
   assign rsp_volume_ch5  = rsp_vol_ff[5];
   assign rsp_fading_mask = rsp_mask_ff;

endmodule

// File: rtl/vfr_checker.sv
// port-level checks for the volume ramp
module vfr_checker #(
   parameter int CHANNELS = 6
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [vfr_pkg::VOL_W-1:0]    rsp_volume_ch0,
   input logic [vfr_pkg::MASK_W-1:0]   rsp_fading_mask
);
   import vfr_pkg::*;

   // result register comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a held word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_volume_ch0)
         && $stable(rsp_fading_mask))
      else $error("stalled result changed");

   // an accepted word keeps the core busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after accept");

   // no result appears out of an idle core with nothing pending
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("result without a word");

   // absent channels never report fading
   a_mask_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (({2'b00, rsp_fading_mask} >> CHANNELS) == '0))
      else $error("fading bit on absent channel");

endmodule

bind volume_fade_ramp vfr_checker #(.CHANNELS(CHANNELS)) u_vfr_checker (.*);
